[design/stt_pkg.sv]
`timescale 1ns / 1ps
package stt_pkg;
	typedef enum logic [2:0] {
		CMD_START = 3'd0, CMD_START_RELOAD = 3'd1, CMD_STOP = 3'd2, CMD_READ = 3'd3,
		CMD_COUNT = 3'd4, CMD_TICK = 3'd5, CMD_NEXT = 3'd6, CMD_CLOCK = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_BAD_EVENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  task_id;
		logic [15:0] event_bits;
		logic [31:0] amount;
	} item_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic        fired;
		logic [7:0]  fired_task;
		logic [15:0] fired_event;
		logic        last;
	} item_out_t;
endpackage

[design/software_timer_table.sv]
`timescale 1ns / 1ps
// Timer table of TIMER_SLOTS slots, scanned one slot per cycle by a single
// shared subtract/compare unit. Every command goes through the accept in
// S_IDLE, a scan of every slot in S_SCAN, then the closing state S_DONE;
// busy is high from the first scan cycle through the closing state, and
// the closing item appears in the cycle after it, when busy is low again and a
// new item may be accepted. A tick emits one fired item per expiring slot
// during the scan, then a closing item with last set. Results are strobed by
// valid for one cycle each and cannot be stalled. All slots are free after reset.
module software_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  stt_pkg::item_in_t  item_in,
	output logic              busy,
	output logic              valid,
	output stt_pkg::item_out_t item_out
);
	import stt_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	logic [7:0]  task_q  [TIMER_SLOTS];
	logic [15:0] event_q [TIMER_SLOTS];
	logic [31:0] rem_q   [TIMER_SLOTS];
	logic [31:0] rel_q   [TIMER_SLOTS];
	logic [31:0] clock_q;

	state_t     state_q, state_d;
	item_in_t   cur_q;
	logic [CW-1:0] idx_q;
	logic       match_found_q, free_found_q, any_q;
	logic [IW-1:0] match_q, free_q;
	logic [31:0] acc_q;

	logic [IW-1:0] idx;
	logic        active, is_match, scan_end, start_cmd;
	logic [31:0] dec;
	logic        valid_d;
	item_out_t   out_d;
	assign idx      = idx_q[IW-1:0];
	assign active   = event_q[idx] != 16'd0;
	assign is_match = active && event_q[idx] == cur_q.event_bits && task_q[idx] == cur_q.task_id;
	assign dec      = (rem_q[idx] > cur_q.amount) ? rem_q[idx] - cur_q.amount : 32'd0;
	assign scan_end = idx_q == CW'(TIMER_SLOTS - 1);
	assign start_cmd = cur_q.cmd == CMD_START || cur_q.cmd == CMD_START_RELOAD;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_SCAN;
			S_SCAN: if (scan_end) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != S_IDLE;
		valid_d = 1'b0;
		out_d = '0;
		unique case (state_q)
			S_SCAN: begin
				if (cur_q.cmd == CMD_TICK && active && dec == 32'd0) begin
					valid_d = 1'b1;
					out_d.fired = 1'b1;
					out_d.fired_task = task_q[idx];
					out_d.fired_event = event_q[idx];
				end
			end
			S_DONE: begin
				valid_d = 1'b1;
				out_d.last = 1'b1;
				unique case (cmd_t'(cur_q.cmd))
					CMD_START, CMD_START_RELOAD: begin
						if (cur_q.event_bits == 16'd0) out_d.status = ST_BAD_EVENT;
						else if (!match_found_q && !free_found_q) out_d.status = ST_FULL;
					end
					CMD_STOP, CMD_READ: begin
						if (cur_q.event_bits == 16'd0) out_d.status = ST_BAD_EVENT;
						else if (!match_found_q) out_d.status = ST_NOT_FOUND;
						else if (cur_q.cmd == CMD_READ) out_d.read_value = rem_q[match_q];
					end
					CMD_COUNT, CMD_NEXT: out_d.read_value = acc_q;
					default: out_d.read_value = clock_q;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid <= 1'b0;
			item_out <= '0;
			cur_q <= '0;
			idx_q <= '0;
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			any_q <= 1'b0;
			match_q <= '0;
			free_q <= '0;
			acc_q <= '0;
			clock_q <= '0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				event_q[i] <= '0;
				task_q[i] <= '0;
				rem_q[i] <= '0;
				rel_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			valid <= valid_d;
			item_out <= out_d;
			unique case (state_q)
				S_IDLE: begin
					cur_q <= item_in;
					idx_q <= '0;
					match_found_q <= 1'b0;
					free_found_q <= 1'b0;
					any_q <= 1'b0;
					acc_q <= '0;
					if (start && item_in.cmd == CMD_TICK)
						clock_q <= clock_q + item_in.amount;
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (is_match && !match_found_q) begin
						match_found_q <= 1'b1;
						match_q <= idx;
					end
					if (!active && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= idx;
					end
					if (cur_q.cmd == CMD_COUNT && active) acc_q <= acc_q + 32'd1;
					if (cur_q.cmd == CMD_NEXT && active && (!any_q || rem_q[idx] < acc_q)) begin
						acc_q <= rem_q[idx];
						any_q <= 1'b1;
					end
					if (cur_q.cmd == CMD_TICK && active) begin
						if (dec == 32'd0) begin
							if (rel_q[idx] != 32'd0) rem_q[idx] <= rel_q[idx];
							else event_q[idx] <= '0;
						end else begin
							rem_q[idx] <= dec;
						end
					end
				end
				S_DONE: begin
					if (start_cmd && cur_q.event_bits != 16'd0) begin
						if (match_found_q) begin
							rem_q[match_q] <= cur_q.amount;
							if (cur_q.cmd == CMD_START_RELOAD) rel_q[match_q] <= cur_q.amount;
						end else if (free_found_q) begin
							task_q[free_q] <= cur_q.task_id;
							event_q[free_q] <= cur_q.event_bits;
							rem_q[free_q] <= cur_q.amount;
							rel_q[free_q] <= (cur_q.cmd == CMD_START_RELOAD) ?
								cur_q.amount : 32'd0;
						end
					end
					if (cur_q.cmd == CMD_STOP && cur_q.event_bits != 16'd0 && match_found_q)
						event_q[match_q] <= '0;
				end
				default: ;
			endcase
		end
	end

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> valid && item_out.last) else $error("missing closing item");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> !valid || $past(state_q) != S_IDLE) else $error("stray item");
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && item_out.fired |-> !item_out.last) else $error("fired item marked last");
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import stt_pkg::*;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	item_in_t item_in;
	logic busy;
	logic valid;
	item_out_t item_out;

	software_timer_table #(.TIMER_SLOTS(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item_in(item_in),
		.busy(busy),
		.valid(valid),
		.item_out(item_out)
	);

	// model state of the timer table
	logic [7:0] tbl_task [SLOTS];
	logic [15:0] tbl_event [SLOTS];
	logic [31:0] tbl_remaining [SLOTS];
	logic [31:0] tbl_reload [SLOTS];
	logic [31:0] tbl_clock;

	item_in_t pending_cmds[$];
	item_out_t expected_results[$];
	int sender_idle_pct;
	int errors = 0;
	int quiet_cycles;
	bit in_taken;
	bit timed_out = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_out_t make_result(logic [1:0] st, logic [31:0] val, logic f,
			logic [7:0] tk, logic [15:0] ev, logic lst);
		item_out_t r;
		r.status = st;
		r.read_value = val;
		r.fired = f;
		r.fired_task = tk;
		r.fired_event = ev;
		r.last = lst;
		return r;
	endfunction

	function automatic int match_slot(logic [7:0] tk, logic [15:0] ev);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_event[i] != 0 && tbl_event[i] == ev && tbl_task[i] == tk)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < SLOTS; i++)
			if (tbl_event[i] == 0)
				return i;
		return -1;
	endfunction

	task automatic predict_timer_cmd(item_in_t c);
		int i;
		logic [31:0] acc;
		bit any;
		case (cmd_t'(c.cmd))
			CMD_START, CMD_START_RELOAD: begin
				if (c.event_bits == 0) begin
					expected_results.push_back(make_result(ST_BAD_EVENT, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					i = match_slot(c.task_id, c.event_bits);
					if (i < 0) begin
						i = free_slot();
						if (i >= 0) begin
							tbl_task[i] = c.task_id;
							tbl_event[i] = c.event_bits;
							tbl_reload[i] = '0;
						end
					end
					if (i < 0) begin
						expected_results.push_back(make_result(ST_FULL, '0, 1'b0, '0, '0, 1'b1));
					end else begin
						tbl_remaining[i] = c.amount;
						if (c.cmd == CMD_START_RELOAD)
							tbl_reload[i] = c.amount;
						expected_results.push_back(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
					end
				end
			end
			CMD_STOP, CMD_READ: begin
				if (c.event_bits == 0) begin
					expected_results.push_back(make_result(ST_BAD_EVENT, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					i = match_slot(c.task_id, c.event_bits);
					if (i < 0) begin
						expected_results.push_back(
							make_result(ST_NOT_FOUND, '0, 1'b0, '0, '0, 1'b1));
					end else if (c.cmd == CMD_STOP) begin
						tbl_event[i] = '0;
						expected_results.push_back(make_result(ST_OK, '0, 1'b0, '0, '0, 1'b1));
					end else begin
						expected_results.push_back(
							make_result(ST_OK, tbl_remaining[i], 1'b0, '0, '0, 1'b1));
					end
				end
			end
			CMD_COUNT: begin
				acc = '0;
				for (i = 0; i < SLOTS; i++)
					if (tbl_event[i] != 0)
						acc++;
				expected_results.push_back(make_result(ST_OK, acc, 1'b0, '0, '0, 1'b1));
			end
			CMD_TICK: begin
				tbl_clock += c.amount;
				for (i = 0; i < SLOTS; i++) begin
					if (tbl_event[i] != 0) begin
						if (tbl_remaining[i] > c.amount)
							tbl_remaining[i] -= c.amount;
						else
							tbl_remaining[i] = '0;
						if (tbl_remaining[i] == 0) begin
							expected_results.push_back(
								make_result(ST_OK, '0, 1'b1, tbl_task[i], tbl_event[i], 1'b0));
							if (tbl_reload[i] != 0)
								tbl_remaining[i] = tbl_reload[i];
							else
								tbl_event[i] = '0;
						end
					end
				end
				expected_results.push_back(make_result(ST_OK, tbl_clock, 1'b0, '0, '0, 1'b1));
			end
			CMD_NEXT: begin
				any = 1'b0;
				acc = '0;
				for (i = 0; i < SLOTS; i++) begin
					if (tbl_event[i] != 0) begin
						if (!any || tbl_remaining[i] < acc)
							acc = tbl_remaining[i];
						any = 1'b1;
					end
				end
				expected_results.push_back(make_result(ST_OK, acc, 1'b0, '0, '0, 1'b1));
			end
			default: begin
				expected_results.push_back(make_result(ST_OK, tbl_clock, 1'b0, '0, '0, 1'b1));
			end
		endcase
	endtask

	function automatic item_in_t mk_cmd(cmd_t op, logic [7:0] tk, logic [15:0] ev,
			logic [31:0] amt);
		item_in_t c;
		c.cmd = op;
		c.task_id = tk;
		c.event_bits = ev;
		c.amount = amt;
		return c;
	endfunction

	// driver: change inputs on the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item_in <= '0;
		end else if (!start || in_taken) begin
			// idle, or previous item accepted at the last rising edge
			if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				item_in <= pending_cmds.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
			in_taken <= 1'b0;
			tbl_clock = '0;
			for (int i = 0; i < SLOTS; i++) begin
				tbl_task[i] = '0;
				tbl_event[i] = '0;
				tbl_remaining[i] = '0;
				tbl_reload[i] = '0;
			end
		end else begin
			in_taken <= start && !busy;
			if ((start && !busy) || valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (start && !busy)
				predict_timer_cmd(item_in);
			if (valid) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: actual %p", $time, item_out);
					errors++;
				end else begin
					item_out_t e;
					e = expected_results.pop_front();
					if (e !== item_out) begin
						$display("%0t mismatch: expected %p actual %p", $time, e, item_out);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(5))
			0: return 0;
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return $urandom;
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		item_in_t c;
		logic [7:0] tk;
		logic [15:0] ev;
		int r;
		sender_idle_pct = 23;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		pending_cmds.push_back(mk_cmd(CMD_NEXT, '0, '0, '0));
		pending_cmds.push_back(mk_cmd(CMD_START, 8'h01, 16'h0000, 32'd5));
		pending_cmds.push_back(mk_cmd(CMD_STOP, 8'h01, 16'h0000, '0));
		pending_cmds.push_back(mk_cmd(CMD_READ, 8'h01, 16'h0000, '0));
		pending_cmds.push_back(mk_cmd(CMD_STOP, 8'h01, 16'h0001, '0));
		pending_cmds.push_back(mk_cmd(CMD_READ, 8'hFF, 16'hFFFF, '0));
		pending_cmds.push_back(mk_cmd(CMD_START, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
		pending_cmds.push_back(mk_cmd(CMD_START_RELOAD, 8'h00, 16'h0001, 32'd3));
		pending_cmds.push_back(mk_cmd(CMD_START, 8'h00, 16'h0001, 32'd7));
		pending_cmds.push_back(mk_cmd(CMD_START, 8'h02, 16'h8000, '0));
		pending_cmds.push_back(mk_cmd(CMD_START_RELOAD, 8'h03, 16'h0002, '0));
		pending_cmds.push_back(mk_cmd(CMD_READ, 8'h00, 16'h0001, '0));
		pending_cmds.push_back(mk_cmd(CMD_COUNT, '0, '0, '0));
		pending_cmds.push_back(mk_cmd(CMD_NEXT, '0, '0, '0));
		pending_cmds.push_back(mk_cmd(CMD_TICK, '0, '0, '0));
		pending_cmds.push_back(mk_cmd(CMD_TICK, '0, '0, 32'd8));
		pending_cmds.push_back(mk_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFF0));
		pending_cmds.push_back(mk_cmd(CMD_CLOCK, '0, '0, '0));
		for (int i = 0; i < 17; i++)
			pending_cmds.push_back(mk_cmd(CMD_START_RELOAD, 8'(i), 16'(i + 16), 32'd2));
		pending_cmds.push_back(mk_cmd(CMD_TICK, '0, '0, 32'd2));
		pending_cmds.push_back(mk_cmd(CMD_STOP, 8'h05, 16'h0015, '0));
		pending_cmds.push_back(mk_cmd(CMD_COUNT, '0, '0, '0));

		// random: sender idles 23 in 100, then 74 in 100, then never
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			sender_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 74 : 0;
			for (int n = 0; n < 55; n++) begin
				tk = 8'($urandom_range(3));
				if ($urandom_range(9) == 0)
					tk = 8'($urandom);
				ev = 16'(1 << $urandom_range(15));
				if ($urandom_range(15) == 0)
					ev = ($urandom_range(1)) ? 16'h0000 : 16'($urandom);
				r = $urandom_range(99);
				if (r < 35)
					c = mk_cmd($urandom_range(1) ? CMD_START_RELOAD : CMD_START, tk, ev,
						rand_amount());
				else if (r < 45)
					c = mk_cmd(CMD_STOP, tk, ev, $urandom);
				else if (r < 55)
					c = mk_cmd(CMD_READ, tk, ev, $urandom);
				else if (r < 80)
					c = mk_cmd(CMD_TICK, tk, ev, rand_amount());
				else
					c = mk_cmd(cmd_t'($urandom_range(4, 7)) == CMD_TICK ? CMD_CLOCK :
						cmd_t'($urandom_range(4, 7)), tk, ev, $urandom);
				pending_cmds.push_back(c);
			end
		end
		wait_drained();
		repeat (SLOTS * 3) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
